// ===== sv/long_indexed_load_execute_macros.svh =====
`ifndef LONG_INDEXED_LOAD_EXECUTE_MACROS_SVH
`define LONG_INDEXED_LOAD_EXECUTE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LILE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LILE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lile_pkg.sv =====
`default_nettype none

package lile_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int WORD_BYTES = 4;
  localparam int PARAM_W    = 16;
  localparam int SUM_W      = WORD_W + 1;

  localparam logic [1:0] KIND_MEM_WRITE = 2'd0;
  localparam logic [1:0] KIND_REG_WRITE = 2'd1;
  localparam logic [1:0] KIND_LOAD      = 2'd2;

  localparam logic [1:0] OPT_REG    = 2'd0;
  localparam logic [1:0] OPT_DIRECT = 2'd1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_MEMW_MOD,
    ST_OP_START,
    ST_OP_REG,
    ST_OP_REM,
    ST_OP_MOD,
    ST_OP_NEXT,
    ST_SUM,
    ST_ADDR_MOD,
    ST_RD,
    ST_RD_TAIL,
    ST_FINISH
  } lile_state_e;

endpackage

`default_nettype wire

// ===== sv/lile_cmod.sv =====
`default_nettype none

module lile_cmod #(
  parameter int WIDTH   = 33,
  parameter int DIVISOR = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [WIDTH-1:0]             x_i,
  output      logic                         done_o,
  output      logic [$clog2(DIVISOR)-1:0]   rem_o
);

  localparam int RW = $clog2(DIVISOR);
  localparam int DW = RW + 1;
  localparam int HW = (WIDTH + 1) / 2;
  localparam int UW = WIDTH - HW;
  localparam int RB = WIDTH - RW + 1;
  localparam int FW = WIDTH + RB;
  localparam logic [63:0] RECIP_W64 = (64'd1 << WIDTH) / 64'(DIVISOR);
  localparam logic [RB-1:0] RECIP = RB'(RECIP_W64);
  localparam logic [DW-1:0] DIV = DW'(DIVISOR);

  logic [WIDTH-1:0]  x_q;
  logic [HW+RB-1:0]  plo_q;
  logic [UW+RB-1:0]  phi_q;
  logic [RB-1:0]     quo_q;
  logic [WIDTH:0]    prod_q;
  logic [RW-1:0]     rem_q;
  logic [2:0]        stage_q;
  logic              rem_load_q;
  logic              done_q;

  logic [FW-1:0]     full;
  logic [WIDTH:0]    diff;
  logic [WIDTH:0]    fixed;

  // The quotient estimate from the truncated reciprocal is low by at most one.
  always_comb begin
    full  = FW'(plo_q) + (FW'(phi_q) << HW);
    diff  = {1'b0, x_q} - prod_q;
    fixed = (diff >= (WIDTH+1)'(DIV)) ? diff - (WIDTH+1)'(DIV) : diff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q    <= '0;
      rem_load_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      stage_q    <= {stage_q[1:0], start_i};
      rem_load_q <= stage_q[2];
      done_q     <= rem_load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
    end
    if (stage_q[0]) begin
      plo_q <= (HW+RB)'(x_q[HW-1:0]) * (HW+RB)'(RECIP);
      phi_q <= (UW+RB)'(x_q[WIDTH-1:HW]) * (UW+RB)'(RECIP);
    end
    if (stage_q[1]) begin
      quo_q <= full[FW-1:WIDTH];
    end
    if (stage_q[2]) begin
      prod_q <= (WIDTH+1)'((RB+DW)'(quo_q) * (RB+DW)'(DIV));
    end
    if (rem_load_q) begin
      rem_q <= RW'(fixed);
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ===== sv/long_indexed_load_execute.sv =====
// Long indexed load unit of a small virtual machine. It holds a circular byte
// arena of MEMORY_BYTES entries, REGISTER_COUNT 32-bit registers and a carry
// flag, and returns exactly one result transaction for every input
// transaction. After reset the arena is cleared one byte per cycle, so no
// input is accepted until the whole arena is cleared. One transaction is
// worked on at a time; a load with indirect operands takes longer than one
// with direct operands, and the result may wait on out_stall_i. The load
// time is set by the single byte-wide arena read port, which fetches each
// 4-byte word one byte a cycle, and by the constant-modulo units that reduce
// the operand index and the effective address.
`default_nettype none

`include "long_indexed_load_execute_macros.svh"

module long_indexed_load_execute #(
  parameter int MEMORY_BYTES   = 4096,
  parameter int INDEX_SPAN     = 512,
  parameter int REGISTER_COUNT = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic [11:0]        mem_address_i,
  input  wire logic [7:0]         mem_byte_i,
  input  wire logic [4:0]         reg_number_i,
  input  wire logic signed [31:0] reg_value_i,
  input  wire logic [11:0]        pc_i,
  input  wire logic [1:0]         first_type_i,
  input  wire logic signed [15:0] first_param_i,
  input  wire logic [1:0]         second_type_i,
  input  wire logic signed [15:0] second_param_i,
  input  wire logic [7:0]         dest_param_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               status_o,
  output      logic signed [31:0] loaded_value_o,
  output      logic [11:0]        load_address_o,
  output      logic               carry_out_o
);

  localparam int AW    = $clog2(MEMORY_BYTES);
  localparam int RIW   = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int IRW   = $clog2(INDEX_SPAN);
  localparam int MOD_W = lile_pkg::SUM_W;
  localparam int BW    = lile_pkg::BYTE_W;
  localparam int WW    = lile_pkg::WORD_W;
  localparam int PW    = lile_pkg::PARAM_W;
  localparam logic [63:0] MEM_W64  = 64'(MEMORY_BYTES);
  localparam logic [63:0] BIAS_W64 = ((64'h8000_0000 + MEM_W64 - 64'd1) / MEM_W64) * MEM_W64;
  localparam logic [MOD_W-1:0] MOD_BIAS = MOD_W'(BIAS_W64);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEMORY_BYTES - 1);
  localparam logic [1:0] LAST_BYTE = 2'(lile_pkg::WORD_BYTES - 1);

  lile_pkg::lile_state_e state_q, state_d;

  logic [1:0]    kind_q;
  logic [11:0]   mem_address_q;
  logic [7:0]    mem_byte_q;
  logic [4:0]    reg_number_q;
  logic [WW-1:0] reg_value_q;
  logic [11:0]   pc_q;
  logic [1:0]    first_type_q;
  logic [PW-1:0] first_param_q;
  logic [1:0]    second_type_q;
  logic [PW-1:0] second_param_q;
  logic [7:0]    dest_param_q;

  logic [AW-1:0] clr_q, clr_d;
  logic          op_q, op_d;
  logic          fin_q, fin_d;
  logic [1:0]    rd_cnt_q, rd_cnt_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic          rd_pend_q;
  logic [WW-1:0] word_q, word_d;
  logic [WW-1:0] val1_q, val1_d, val2_q, val2_d;
  logic          carry_q, carry_d;
  logic          res_status_q, res_status_d;
  logic [WW-1:0] res_loaded_q, res_loaded_d;
  logic [AW-1:0] res_addr_q, res_addr_d;

  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic          out_status_q;
  logic [WW-1:0] out_loaded_q;
  logic [11:0]   out_addr_q;
  logic          out_carry_q;

  logic [BW-1:0] arena_q [MEMORY_BYTES];
  logic          ar_we, ar_re;
  logic [AW-1:0] ar_waddr, ar_raddr;
  logic [BW-1:0] ar_wdata, ar_rdata_q;

  logic [WW-1:0] rf_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld_q;
  logic          rf_we, rf_re;
  logic [RIW-1:0] rf_waddr, rf_raddr;
  logic [WW-1:0] rf_wdata, rf_rdata_q;

  logic             rem_start, rem_done;
  logic             mod_start, mod_done;
  logic [PW-1:0]    rem_x;
  logic [IRW-1:0]   rem_val;
  logic [MOD_W-1:0] mod_x;
  logic [AW-1:0]    mod_val;

  logic          in_accept;
  logic [1:0]    cur_type;
  logic [PW-1:0] cur_param;
  logic [PW-1:0] cur_abs;
  logic [MOD_W-1:0] srem, u_ind, u_fin;
  logic [WW-1:0] sum;
  logic [WW-1:0] cur_direct;
  logic          dest_ok, reg_num_ok, op1_ok, op2_ok;

  function automatic logic param_reg_ok(input logic [15:0] p);
    param_reg_ok = !p[15] && (p != 16'd0) && ({1'b0, p} <= 17'(REGISTER_COUNT));
  endfunction

  lile_cmod #(
    .WIDTH   (PW),
    .DIVISOR (INDEX_SPAN)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .x_i     (rem_x),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  lile_cmod #(
    .WIDTH   (MOD_W),
    .DIVISOR (MEMORY_BYTES)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x),
    .done_o  (mod_done),
    .rem_o   (mod_val)
  );

  assign in_stall_o = (state_q != lile_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    cur_type   = op_q ? second_type_q : first_type_q;
    cur_param  = op_q ? second_param_q : first_param_q;
    cur_abs    = cur_param[PW-1] ? PW'(-cur_param) : cur_param;
    cur_direct = {{(WW-PW){cur_param[PW-1]}}, cur_param};
    srem       = cur_param[PW-1] ? MOD_W'(-MOD_W'(rem_val)) : MOD_W'(rem_val);
    u_ind      = MOD_W'(pc_q) + srem + MOD_BIAS;
    sum        = val1_q + val2_q;
    u_fin      = MOD_W'(pc_q) + {sum[WW-1], sum} + MOD_BIAS;
    word_d     = rd_pend_q ? {word_q[WW-BW-1:0], ar_rdata_q} : word_q;
    dest_ok    = (dest_param_q != 8'd0) && (9'(dest_param_q) <= 9'(REGISTER_COUNT));
    reg_num_ok = (reg_number_q != 5'd0) && (8'(reg_number_q) <= 8'(REGISTER_COUNT));
    op1_ok     = (first_type_q != lile_pkg::OPT_REG) || param_reg_ok(first_param_q);
    op2_ok     = (second_type_q != lile_pkg::OPT_REG) || param_reg_ok(second_param_q);
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    op_d          = op_q;
    fin_d         = fin_q;
    rd_cnt_d      = rd_cnt_q;
    rd_addr_d     = rd_addr_q;
    val1_d        = val1_q;
    val2_d        = val2_q;
    carry_d       = carry_q;
    res_status_d  = res_status_q;
    res_loaded_d  = res_loaded_q;
    res_addr_d    = res_addr_q;
    out_load      = 1'b0;
    ar_we         = 1'b0;
    ar_waddr      = clr_q;
    ar_wdata      = '0;
    ar_re         = 1'b0;
    ar_raddr      = rd_addr_q;
    rf_we         = 1'b0;
    rf_waddr      = RIW'(dest_param_q - 8'd1);
    rf_wdata      = word_d;
    rf_re         = 1'b0;
    rf_raddr      = RIW'(cur_param - 16'd1);
    rem_start     = 1'b0;
    rem_x         = cur_abs;
    mod_start     = 1'b0;
    mod_x         = u_fin;

    unique case (state_q)
      lile_pkg::ST_CLEAR: begin
        ar_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = lile_pkg::ST_IDLE;
        end
      end
      lile_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = lile_pkg::ST_DISPATCH;
        end
      end
      lile_pkg::ST_DISPATCH: begin
        res_status_d = 1'b0;
        res_loaded_d = '0;
        res_addr_d   = '0;
        unique case (kind_q)
          lile_pkg::KIND_MEM_WRITE: begin
            mod_start = 1'b1;
            mod_x     = MOD_W'(mem_address_q);
            state_d   = lile_pkg::ST_MEMW_MOD;
          end
          lile_pkg::KIND_REG_WRITE: begin
            if (reg_num_ok) begin
              rf_we    = 1'b1;
              rf_waddr = RIW'(reg_number_q - 5'd1);
              rf_wdata = reg_value_q;
            end else begin
              res_status_d = 1'b1;
            end
            state_d = lile_pkg::ST_FINISH;
          end
          lile_pkg::KIND_LOAD: begin
            if (dest_ok && op1_ok && op2_ok) begin
              op_d    = 1'b0;
              state_d = lile_pkg::ST_OP_START;
            end else begin
              res_status_d = 1'b1;
              state_d      = lile_pkg::ST_FINISH;
            end
          end
          default: begin
            state_d = lile_pkg::ST_FINISH;
          end
        endcase
      end
      lile_pkg::ST_MEMW_MOD: begin
        if (mod_done) begin
          ar_we    = 1'b1;
          ar_waddr = mod_val;
          ar_wdata = mem_byte_q;
          state_d  = lile_pkg::ST_FINISH;
        end
      end
      lile_pkg::ST_OP_START: begin
        unique case (cur_type)
          lile_pkg::OPT_REG: begin
            rf_re   = 1'b1;
            state_d = lile_pkg::ST_OP_REG;
          end
          lile_pkg::OPT_DIRECT: begin
            if (op_q) begin
              val2_d = cur_direct;
            end else begin
              val1_d = cur_direct;
            end
            state_d = lile_pkg::ST_OP_NEXT;
          end
          default: begin
            rem_start = 1'b1;
            state_d   = lile_pkg::ST_OP_REM;
          end
        endcase
      end
      lile_pkg::ST_OP_REG: begin
        if (op_q) begin
          val2_d = rf_rdata_q;
        end else begin
          val1_d = rf_rdata_q;
        end
        state_d = lile_pkg::ST_OP_NEXT;
      end
      lile_pkg::ST_OP_REM: begin
        if (rem_done) begin
          mod_start = 1'b1;
          mod_x     = u_ind;
          state_d   = lile_pkg::ST_OP_MOD;
        end
      end
      lile_pkg::ST_OP_MOD: begin
        if (mod_done) begin
          rd_addr_d = mod_val;
          rd_cnt_d  = 2'd0;
          fin_d     = 1'b0;
          state_d   = lile_pkg::ST_RD;
        end
      end
      lile_pkg::ST_OP_NEXT: begin
        if (!op_q) begin
          op_d    = 1'b1;
          state_d = lile_pkg::ST_OP_START;
        end else begin
          state_d = lile_pkg::ST_SUM;
        end
      end
      lile_pkg::ST_SUM: begin
        mod_start = 1'b1;
        state_d   = lile_pkg::ST_ADDR_MOD;
      end
      lile_pkg::ST_ADDR_MOD: begin
        if (mod_done) begin
          res_addr_d = mod_val;
          rd_addr_d  = mod_val;
          rd_cnt_d   = 2'd0;
          fin_d      = 1'b1;
          state_d    = lile_pkg::ST_RD;
        end
      end
      lile_pkg::ST_RD: begin
        ar_re     = 1'b1;
        rd_addr_d = (rd_addr_q == LAST_ADDR) ? '0 : rd_addr_q + 1'b1;
        rd_cnt_d  = rd_cnt_q + 2'd1;
        if (rd_cnt_q == LAST_BYTE) begin
          state_d = lile_pkg::ST_RD_TAIL;
        end
      end
      lile_pkg::ST_RD_TAIL: begin
        if (fin_q) begin
          rf_we        = 1'b1;
          res_loaded_d = word_d;
          carry_d      = (word_d == '0);
          state_d      = lile_pkg::ST_FINISH;
        end else begin
          if (op_q) begin
            val2_d = word_d;
          end else begin
            val1_d = word_d;
          end
          state_d = lile_pkg::ST_OP_NEXT;
        end
      end
      lile_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = lile_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lile_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lile_pkg::ST_CLEAR;
      clr_q       <= '0;
      op_q        <= 1'b0;
      fin_q       <= 1'b0;
      rd_cnt_q    <= '0;
      rd_pend_q   <= 1'b0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
      rf_vld_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      op_q        <= op_d;
      fin_q       <= fin_d;
      rd_cnt_q    <= rd_cnt_d;
      rd_pend_q   <= ar_re;
      carry_q     <= carry_d;
      out_valid_q <= out_valid_d;
      if (rf_we) begin
        rf_vld_q[rf_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q         <= kind_i;
      mem_address_q  <= mem_address_i;
      mem_byte_q     <= mem_byte_i;
      reg_number_q   <= reg_number_i;
      reg_value_q    <= reg_value_i;
      pc_q           <= pc_i;
      first_type_q   <= first_type_i;
      first_param_q  <= first_param_i;
      second_type_q  <= second_type_i;
      second_param_q <= second_param_i;
      dest_param_q   <= dest_param_i;
    end
    rd_addr_q    <= rd_addr_d;
    word_q       <= word_d;
    val1_q       <= val1_d;
    val2_q       <= val2_d;
    res_status_q <= res_status_d;
    res_loaded_q <= res_loaded_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      out_status_q <= res_status_d;
      out_loaded_q <= res_loaded_d;
      out_addr_q   <= 12'(res_addr_d);
      out_carry_q  <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ar_we) begin
      arena_q[ar_waddr] <= ar_wdata;
    end
    if (ar_re) begin
      ar_rdata_q <= arena_q[ar_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
    if (rf_re) begin
      rf_rdata_q <= rf_vld_q[rf_raddr] ? rf_q[rf_raddr] : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign loaded_value_o = out_loaded_q;
  assign load_address_o = out_addr_q;
  assign carry_out_o    = out_carry_q;

  `LILE_ASSERT_IMP(a_mod_done_awaited, mod_done,
                   (state_q == lile_pkg::ST_MEMW_MOD) || (state_q == lile_pkg::ST_OP_MOD) ||
                   (state_q == lile_pkg::ST_ADDR_MOD),
                   "Modulo result arrived while no state waits for it.")
  `LILE_ASSERT_IMP(a_rem_done_awaited, rem_done, state_q == lile_pkg::ST_OP_REM,
                   "Index remainder arrived while no state waits for it.")
  `LILE_ASSERT_IMP(a_tail_has_byte, state_q == lile_pkg::ST_RD_TAIL,
                   rd_pend_q && (rd_cnt_q == 2'd0),
                   "Word assembly finished without its last byte.")
  `LILE_ASSERT_IMP(a_out_from_finish, $rose(out_valid_o),
                   $past(state_q == lile_pkg::ST_FINISH),
                   "Result presented without a finished transaction.")
  `LILE_ASSERT_IMP(a_carry_on_load, !$stable(carry_q),
                   $past((state_q == lile_pkg::ST_RD_TAIL) && fin_q),
                   "Carry changed outside the final load.")

endmodule

`default_nettype wire
